@@ rtl/core/phar_pkg.sv @@
// Shared types, register indexes and range rounding for the peak hold autorange block.
package phar_pkg;

    localparam int SAMPLE_W = 32;
    localparam int RANGE_W  = 33;
    localparam int HOLD_W   = 8;
    localparam int CFG_IDX_W = 2;

    localparam logic [CFG_IDX_W-1:0] CFG_FIXED_EN    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_FIXED_RANGE = 2'd1;

    typedef enum logic [2:0] {
        S_IDLE,
        S_EVAL,
        S_SCAN,
        S_ROUND,
        S_WRITE,
        S_OUT
    } t_state;

    // smallest power of two at or above v, never below 2
    function automatic logic [RANGE_W-1:0] round_pow2(input logic [SAMPLE_W-1:0] v);
        logic [RANGE_W-1:0] x;
        x = {1'b0, v} - RANGE_W'(1);
        x = x | (x >> 1);
        x = x | (x >> 2);
        x = x | (x >> 4);
        x = x | (x >> 8);
        x = x | (x >> 16);
        if (v <= SAMPLE_W'(2)) begin
            return RANGE_W'(2);
        end
        return x + RANGE_W'(1);
    endfunction

endpackage

@@ rtl/core/peak_hold_autorange_top.sv @@
// Peak hold autorange: power-of-two full-scale range with history rescan.
// A word accepted in idle passes through the evaluate, write and output states; when the hold
// runs out, a history rescan state and a rounding state come before the write (one history RAM read per cycle).
// New words are stalled until the result word is loaded into the output register; one word in flight.
// Synchronous active-low reset; the history needs no clearing pass, a fill count
// marks slots never written, which the rescan skips.
module peak_hold_autorange_top #(
    parameter int HISTORY_DEPTH = 256,
    parameter int HOLD_TICKS    = 180
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_in_valid,
    output logic                               o_in_stall,
    input  logic [phar_pkg::SAMPLE_W-1:0]      i_sample_value,
    output logic                               o_out_valid,
    input  logic                               i_out_stall,
    output logic [phar_pkg::RANGE_W-1:0]       o_auto_range,
    output logic [phar_pkg::RANGE_W-1:0]       o_display_range,
    output logic [phar_pkg::HOLD_W-1:0]        o_hold_count,
    output logic                               o_rescanned,
    input  logic                               i_cfg_we,
    input  logic [phar_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [phar_pkg::SAMPLE_W-1:0]      i_cfg_data
);
    import phar_pkg::*;

    localparam int PW = $clog2(HISTORY_DEPTH);
    localparam int FW = $clog2(HISTORY_DEPTH + 1);
    localparam int AW = $clog2(HOLD_TICKS + 1);
    localparam int TW = $clog2(HOLD_TICKS);
    localparam logic [PW-1:0] LAST_SLOT = PW'(HISTORY_DEPTH - 1);
    localparam logic [FW-1:0] FULL_CNT  = FW'(HISTORY_DEPTH);
    localparam logic [AW-1:0] HOLD_CNT  = AW'(HOLD_TICKS);

    t_state r_state, n_state;
    logic [SAMPLE_W-1:0] r_sample, n_sample;
    logic [RANGE_W-1:0]  r_range, n_range;
    logic [TW-1:0]       r_ticks, n_ticks;
    logic [PW-1:0]       r_wp, n_wp;
    logic [FW-1:0]       r_fill, n_fill;
    logic                r_scan, n_scan;
    logic [SAMPLE_W-1:0] r_best, n_best;
    logic [TW-1:0]       r_best_age, n_best_age;
    logic [AW-1:0]       r_age, n_age;
    logic [PW-1:0]       r_idx, n_idx;
    logic                r_pend, n_pend;
    logic [TW-1:0]       r_pend_age, n_pend_age;
    logic                r_pend_ok, n_pend_ok;
    logic                r_out_valid, n_out_valid;
    logic [RANGE_W-1:0]  r_out_auto, n_out_auto;
    logic [RANGE_W-1:0]  r_out_disp, n_out_disp;
    logic [HOLD_W-1:0]   r_out_hold, n_out_hold;
    logic                r_out_scan, n_out_scan;
    logic                r_fix_en;
    logic [SAMPLE_W-1:0] r_fix_range;

    logic                ram_we, ram_re;
    logic [PW-1:0]       ram_waddr;
    logic [SAMPLE_W-1:0] ram_rdata;
    logic [AW-1:0]       ticks_inc;
    logic [PW-1:0]       wp_next;
    logic                slot_written;
    logic                out_free;

    phar_ram #(
        .WIDTH (SAMPLE_W),
        .DEPTH (HISTORY_DEPTH)
    ) u_hist (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (r_sample),
        .i_re    (ram_re),
        .i_raddr (r_idx),
        .o_rdata (ram_rdata)
    );

    assign ticks_inc    = AW'(r_ticks) + AW'(1);
    assign wp_next      = (r_wp == LAST_SLOT) ? '0 : r_wp + PW'(1);
    assign slot_written = (r_fill == FULL_CNT) ||
                          ((r_idx != '0) && (FW'(r_idx) <= r_fill));
    assign out_free     = !r_out_valid || !i_out_stall;

    always_comb begin
        n_state     = r_state;
        n_sample    = r_sample;
        n_range     = r_range;
        n_ticks     = r_ticks;
        n_wp        = r_wp;
        n_fill      = r_fill;
        n_scan      = r_scan;
        n_best      = r_best;
        n_best_age  = r_best_age;
        n_age       = r_age;
        n_idx       = r_idx;
        n_pend      = r_pend;
        n_pend_age  = r_pend_age;
        n_pend_ok   = r_pend_ok;
        n_out_valid = r_out_valid && i_out_stall;
        n_out_auto  = r_out_auto;
        n_out_disp  = r_out_disp;
        n_out_hold  = r_out_hold;
        n_out_scan  = r_out_scan;
        ram_we      = 1'b0;
        ram_re      = 1'b0;
        ram_waddr   = wp_next;
        o_in_stall  = (r_state != S_IDLE);

        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_sample = i_sample_value;
                    n_state  = S_EVAL;
                end
            end
            S_EVAL: begin
                n_scan = 1'b0;
                if ({1'b0, r_sample} > r_range) begin
                    n_range = round_pow2(r_sample);
                    n_ticks = '0;
                    n_state = S_WRITE;
                end else if (ticks_inc >= HOLD_CNT) begin
                    n_best     = r_sample;
                    n_best_age = '0;
                    n_age      = AW'(1);
                    n_idx      = r_wp;
                    n_pend     = 1'b0;
                    n_state    = S_SCAN;
                end else begin
                    n_ticks = TW'(ticks_inc);
                    n_state = S_WRITE;
                end
            end
            S_SCAN: begin
                if (r_age != HOLD_CNT) begin
                    ram_re     = 1'b1;
                    n_pend     = 1'b1;
                    n_pend_age = TW'(r_age);
                    n_pend_ok  = slot_written;
                    n_age      = r_age + AW'(1);
                    n_idx      = (r_idx == '0) ? LAST_SLOT : r_idx - PW'(1);
                end else begin
                    n_pend = 1'b0;
                    if (!r_pend) begin
                        n_state = S_ROUND;
                    end
                end
                if (r_pend && r_pend_ok && (ram_rdata > r_best)) begin
                    n_best     = ram_rdata;
                    n_best_age = r_pend_age;
                end
            end
            S_ROUND: begin
                n_range = round_pow2(r_best);
                n_ticks = r_best_age;
                n_scan  = 1'b1;
                n_state = S_WRITE;
            end
            S_WRITE: begin
                ram_we  = 1'b1;
                n_wp    = wp_next;
                n_fill  = (r_fill == FULL_CNT) ? r_fill : r_fill + FW'(1);
                n_state = S_OUT;
            end
            S_OUT: begin
                if (out_free) begin
                    n_out_valid = 1'b1;
                    n_out_auto  = r_range;
                    n_out_disp  = r_fix_en ? {1'b0, r_fix_range} : r_range;
                    n_out_hold  = HOLD_W'(r_ticks);
                    n_out_scan  = r_scan;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_range     <= RANGE_W'(1);
            r_ticks     <= '0;
            r_wp        <= '0;
            r_fill      <= '0;
            r_pend      <= 1'b0;
            r_out_valid <= 1'b0;
            r_fix_en    <= 1'b0;
            r_fix_range <= SAMPLE_W'(1);
        end else begin
            r_state     <= n_state;
            r_range     <= n_range;
            r_ticks     <= n_ticks;
            r_wp        <= n_wp;
            r_fill      <= n_fill;
            r_pend      <= n_pend;
            r_out_valid <= n_out_valid;
            if (i_cfg_we) begin
                unique case (i_cfg_index)
                    CFG_FIXED_EN: begin
                        r_fix_en <= i_cfg_data[0];
                    end
                    CFG_FIXED_RANGE: begin
                        r_fix_range <= i_cfg_data;
                    end
                    default: begin
                    end
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_sample   <= n_sample;
        r_scan     <= n_scan;
        r_best     <= n_best;
        r_best_age <= n_best_age;
        r_age      <= n_age;
        r_idx      <= n_idx;
        r_pend_age <= n_pend_age;
        r_pend_ok  <= n_pend_ok;
        r_out_auto <= n_out_auto;
        r_out_disp <= n_out_disp;
        r_out_hold <= n_out_hold;
        r_out_scan <= n_out_scan;
    end

    assign o_out_valid     = r_out_valid;
    assign o_auto_range    = r_out_auto;
    assign o_display_range = r_out_disp;
    assign o_hold_count    = r_out_hold;
    assign o_rescanned     = r_out_scan;

endmodule

@@ rtl/core/phar_ram.sv @@
// Generic single-port-write, single-port-read RAM with registered read data.
module phar_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

@@ rtl/core/phar_chk.sv @@
// Port-level checker for the peak hold autorange top level, with its bind.
module phar_chk #(
    parameter int HOLD_TICKS = 180
) (
    input logic                           i_clk,
    input logic                           i_rst_n,
    input logic                           i_in_valid,
    input logic                           o_in_stall,
    input logic                           o_out_valid,
    input logic                           i_out_stall,
    input logic [phar_pkg::RANGE_W-1:0]   o_auto_range,
    input logic [phar_pkg::RANGE_W-1:0]   o_display_range,
    input logic [phar_pkg::HOLD_W-1:0]    o_hold_count,
    input logic                           o_rescanned
);
    import phar_pkg::*;

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_auto_range) &&
            $stable(o_display_range) && $stable(o_hold_count) && $stable(o_rescanned))
        else $error("stalled result word changed");

    a_range_pow2: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> $onehot(o_auto_range))
        else $error("auto range is not a power of two");

    a_hold_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (32'(o_hold_count) < HOLD_TICKS))
        else $error("hold count reached the hold limit");

    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_stall |=> o_in_stall)
        else $error("second word accepted while one is in flight");

endmodule

bind peak_hold_autorange_top phar_chk #(.HOLD_TICKS(HOLD_TICKS)) u_phar_chk (.*);
